>>> rtl/core/acl_pkg.sv
// Shared types and constants of the assembly source lexer.
// Holds the word layouts, token kinds, error codes and character codes.
// No dependencies.
`default_nettype none

package acl_pkg;

  // Width of the saturating column, space and length counters.
  localparam int CountWidth = 16;
  // Most records that one source byte can give rise to.
  localparam int MaxResults = 3;
  localparam int ResCntWidth = $clog2(MaxResults + 1);
  localparam int ResIdxWidth = $clog2(MaxResults);
  // Depth of the step queue between front and back.
  localparam int QueueDepth = 4;

  // Record kinds.
  localparam logic [3:0] KindPayload = 4'd0;
  localparam logic [3:0] KindWord    = 4'd1;
  localparam logic [3:0] KindString  = 4'd2;
  localparam logic [3:0] KindChar    = 4'd3;
  localparam logic [3:0] KindOper    = 4'd4;
  localparam logic [3:0] KindComma   = 4'd5;
  localparam logic [3:0] KindPunct   = 4'd6;
  localparam logic [3:0] KindBracket = 4'd7;
  localparam logic [3:0] KindEol     = 4'd8;
  localparam logic [3:0] KindEof     = 4'd9;
  localparam logic [3:0] KindError   = 4'd10;

  // Error codes.
  localparam logic [1:0] ErrNone       = 2'd0;
  localparam logic [1:0] ErrEscape     = 2'd1;
  localparam logic [1:0] ErrEscLineEnd = 2'd2;
  localparam logic [1:0] ErrNoClose    = 2'd3;

  // Character codes.
  localparam logic [7:0] CharLf       = 8'd10;
  localparam logic [7:0] CharSpace    = 8'd32;
  localparam logic [7:0] CharComma    = 8'h2c;
  localparam logic [7:0] CharColon    = 8'h3a;
  localparam logic [7:0] CharSemi     = 8'h3b;
  localparam logic [7:0] CharDquote   = 8'h22;
  localparam logic [7:0] CharSquote   = 8'h27;
  localparam logic [7:0] CharBslash   = 8'h5c;
  localparam logic [7:0] CharN        = 8'h6e;
  localparam logic [7:0] CommentReset = 8'd59;

  // Input word: one source byte or the end-of-source mark.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } in_item_t;

  // Output word.
  typedef struct packed {
    logic [3:0]  result_kind;
    logic [7:0]  value_byte;
    logic [31:0] line_number;
    logic [15:0] column;
    logic [15:0] space_count;
    logic [15:0] token_length;
    logic [1:0]  error_code;
    logic        last_of_step;
  } out_item_t;

  // One record as the front produces it; the back adds the step marker.
  typedef struct packed {
    logic [3:0]  result_kind;
    logic [7:0]  value_byte;
    logic [31:0] line_number;
    logic [15:0] column;
    logic [15:0] space_count;
    logic [15:0] token_length;
    logic [1:0]  error_code;
  } token_t;

  // All records of one source byte, oldest in entry 0.
  typedef struct packed {
    logic [ResCntWidth-1:0]          count;
    token_t [MaxResults-1:0]         recs;
  } step_t;

endpackage

`default_nettype wire

>>> rtl/core/acl_front.sv
// Front of the lexer: accepts source bytes, keeps the lexing state and
// gathers the records of each byte into one step word for the queue.
// Depends on acl_pkg.
`default_nettype none

module acl_front import acl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       q_ready_i,
  output logic       q_push_o,
  output step_t      q_step_o
);

  // Lexer modes.
  localparam logic [3:0] ModeLead     = 4'd0;
  localparam logic [3:0] ModeGap      = 4'd1;
  localparam logic [3:0] ModeWord     = 4'd2;
  localparam logic [3:0] ModeStr      = 4'd3;
  localparam logic [3:0] ModeStrEsc   = 4'd4;
  localparam logic [3:0] ModeChrOpen  = 4'd5;
  localparam logic [3:0] ModeChrEsc   = 4'd6;
  localparam logic [3:0] ModeChrClose = 4'd7;
  localparam logic [3:0] ModeComment  = 4'd8;
  localparam logic [3:0] ModeSkip     = 4'd9;

  typedef logic [CountWidth-1:0] cnt_t;

  function automatic cnt_t sat_inc(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [31:0] line_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CharSpace) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return c == 8'h2b || c == 8'h2d || c == 8'h2a || c == 8'h2f || c == 8'h25;
  endfunction

  function automatic logic is_bracket(input logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h5b || c == 8'h5d ||
           c == 8'h7b || c == 8'h7d;
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    return is_space(c) || is_oper(c) || is_bracket(c) || c == CharComma ||
           c == CharSemi || c == CharColon || c == CharDquote || c == CharSquote;
  endfunction

  // Escape decode: bit 8 flags a known escape, the low bits give its value.
  function automatic logic [8:0] esc_decode(input logic [7:0] c);
    logic [8:0] r;
    r = '0;
    if (c == CharBslash || c == CharDquote || c == CharSquote) begin
      r = {1'b1, c};
    end else if (c == CharN) begin
      r = {1'b1, CharLf};
    end
    return r;
  endfunction

  function automatic token_t mk(input logic [3:0] kind, input logic [7:0] val,
                                input logic [31:0] line, input cnt_t col,
                                input cnt_t sp, input cnt_t len,
                                input logic [1:0] err);
    token_t t;
    t.result_kind  = kind;
    t.value_byte   = val;
    t.line_number  = line;
    t.column       = 16'(col);
    t.space_count  = 16'(sp);
    t.token_length = 16'(len);
    t.error_code   = err;
    return t;
  endfunction

  logic [7:0]  cchar_q;
  logic [3:0]  mode_q, mode_d;
  logic [31:0] line_q, line_d;
  cnt_t        col_q, col_d;
  cnt_t        pend_q, pend_d;
  cnt_t        lead_q, lead_d;
  cnt_t        tstart_q, tstart_d;
  cnt_t        tcount_q, tcount_d;
  logic [7:0]  lit_q, lit_d;
  logic        has_q, has_d;
  logic        halted_q, halted_d;

  logic        fire;
  logic [7:0]  b;
  cnt_t        end_col;
  logic [8:0]  esc;

  logic        close_emit, close_err;
  token_t      close_rec;

  cnt_t        gp;
  logic [3:0]  gap_mode;
  cnt_t        gap_pend;
  logic        gap_emit, gap_start, gap_cnt_load;
  cnt_t        gap_cnt;
  token_t      gap_rec;

  logic        use_gap, nl;
  logic [31:0] nl_line;
  logic [ResCntWidth-1:0] n;
  token_t      rec [MaxResults];

  assign fire       = in_valid_i && q_ready_i;
  assign in_ready_o = q_ready_i;
  assign b          = in_item_i.char_code;
  assign end_col    = sat_inc(col_q);
  assign esc        = esc_decode(b);

  // What closing the open token gives when line content ends here.
  always_comb begin
    close_emit = 1'b0;
    close_err  = 1'b0;
    close_rec  = '0;
    unique case (mode_q)
      ModeWord: begin
        close_emit = 1'b1;
        close_rec  = mk(KindWord, 8'd0, line_q, tstart_q, pend_q, tcount_q, ErrNone);
      end
      ModeStr: begin
        close_emit = 1'b1;
        close_rec  = mk(KindString, 8'd0, line_q, tstart_q, pend_q, tcount_q, ErrNone);
      end
      ModeStrEsc: begin
        close_emit = 1'b1;
        close_err  = 1'b1;
        close_rec  = mk(KindError, 8'd0, line_q, end_col, '0, '0, ErrEscape);
      end
      ModeChrEsc: begin
        close_emit = 1'b1;
        close_err  = 1'b1;
        close_rec  = mk(KindError, 8'd0, line_q, end_col, '0, '0, ErrEscLineEnd);
      end
      ModeChrOpen, ModeChrClose: begin
        close_emit = 1'b1;
        close_err  = 1'b1;
        close_rec  = mk(KindError, 8'd0, line_q, end_col, '0, '0, ErrNoClose);
      end
      default: begin
      end
    endcase
  end

  // Classification of a byte that starts something new between tokens.
  // A word just closed by this byte has already taken the pending spaces.
  always_comb begin
    gp           = (mode_q == ModeWord) ? '0 : pend_q;
    gap_mode     = ModeGap;
    gap_pend     = gp;
    gap_emit     = 1'b0;
    gap_start    = 1'b0;
    gap_cnt_load = 1'b0;
    gap_cnt      = '0;
    gap_rec      = '0;
    if (is_space(b)) begin
      gap_pend = sat_inc(gp);
    end else if (b == CharComma) begin
      gap_emit = 1'b1;
      gap_pend = '0;
      gap_rec  = mk(KindComma, b, line_q, end_col, gp, '0, ErrNone);
    end else if (b == CharSemi || b == CharColon) begin
      gap_emit = 1'b1;
      gap_pend = '0;
      gap_rec  = mk(KindPunct, b, line_q, end_col, gp, '0, ErrNone);
    end else if (is_oper(b)) begin
      gap_emit = 1'b1;
      gap_pend = '0;
      gap_rec  = mk(KindOper, b, line_q, end_col, gp, '0, ErrNone);
    end else if (is_bracket(b)) begin
      gap_emit = 1'b1;
      gap_pend = '0;
      gap_rec  = mk(KindBracket, b, line_q, end_col, gp, '0, ErrNone);
    end else if (b == CharDquote) begin
      gap_mode     = ModeStr;
      gap_start    = 1'b1;
      gap_cnt_load = 1'b1;
    end else if (b == CharSquote) begin
      gap_mode  = ModeChrOpen;
      gap_start = 1'b1;
    end else begin
      gap_mode     = ModeWord;
      gap_start    = 1'b1;
      gap_cnt_load = 1'b1;
      gap_cnt      = cnt_t'(1);
      gap_emit     = 1'b1;
      gap_rec      = mk(KindPayload, b, line_q, end_col, '0, '0, ErrNone);
    end
  end

  // Main step: next state and the records of this byte, in order.
  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    col_d    = col_q;
    pend_d   = pend_q;
    lead_d   = lead_q;
    tstart_d = tstart_q;
    tcount_d = tcount_q;
    lit_d    = lit_q;
    has_d    = has_q;
    halted_d = halted_q;
    use_gap  = 1'b0;
    nl       = 1'b0;
    nl_line  = line_q;
    n        = '0;
    for (int i = 0; i < MaxResults; i++) begin
      rec[i] = '0;
    end

    if (!halted_q) begin
      if (in_item_i.end_of_input) begin
        if (has_q) begin
          if (close_emit) begin
            rec[n] = close_rec;
            n      = n + 1'b1;
          end
          if (close_err) begin
            halted_d = 1'b1;
          end else begin
            if (mode_q != ModeSkip) begin
              rec[n] = mk(KindEol, 8'd0, line_q, end_col, lead_q, '0, ErrNone);
              n      = n + 1'b1;
            end
            rec[n]  = mk(KindEof, 8'd0, line_inc(line_q), '0, '0, '0, ErrNone);
            n       = n + 1'b1;
            nl      = 1'b1;
            nl_line = 32'd1;
          end
        end else begin
          rec[n]  = mk(KindEof, 8'd0, line_q, '0, '0, '0, ErrNone);
          n       = n + 1'b1;
          nl      = 1'b1;
          nl_line = 32'd1;
        end
      end else if (b == CharLf) begin
        if (close_emit) begin
          rec[n] = close_rec;
          n      = n + 1'b1;
        end
        if (close_err) begin
          halted_d = 1'b1;
        end else begin
          if (mode_q != ModeSkip) begin
            rec[n] = mk(KindEol, 8'd0, line_q, end_col, lead_q, '0, ErrNone);
            n      = n + 1'b1;
          end
          nl      = 1'b1;
          nl_line = line_inc(line_q);
        end
      end else begin
        has_d = 1'b1;
        if (mode_q == ModeSkip || mode_q == ModeComment) begin
          // Rest of the line is comment.
        end else if (b == cchar_q) begin
          if (mode_q == ModeLead) begin
            mode_d = ModeSkip;
          end else begin
            if (close_emit) begin
              rec[n] = close_rec;
              n      = n + 1'b1;
            end
            if (close_err) begin
              halted_d = 1'b1;
            end else begin
              mode_d = ModeComment;
              pend_d = '0;
            end
          end
        end else begin
          col_d = end_col;
          unique case (mode_q)
            ModeLead: begin
              if (is_space(b)) begin
                lead_d = sat_inc(lead_q);
                pend_d = sat_inc(pend_q);
              end else begin
                use_gap = 1'b1;
              end
            end
            ModeWord: begin
              if (ends_word(b)) begin
                rec[n]  = close_rec;
                n       = n + 1'b1;
                use_gap = 1'b1;
              end else begin
                tcount_d = sat_inc(tcount_q);
                rec[n]   = mk(KindPayload, b, line_q, end_col, '0, '0, ErrNone);
                n        = n + 1'b1;
              end
            end
            ModeStr: begin
              if (b == CharDquote) begin
                rec[n] = close_rec;
                n      = n + 1'b1;
                pend_d = '0;
                mode_d = ModeGap;
              end else if (b == CharBslash) begin
                mode_d = ModeStrEsc;
              end else begin
                tcount_d = sat_inc(tcount_q);
                rec[n]   = mk(KindPayload, b, line_q, end_col, '0, '0, ErrNone);
                n        = n + 1'b1;
              end
            end
            ModeStrEsc: begin
              if (esc[8]) begin
                tcount_d = sat_inc(tcount_q);
                rec[n]   = mk(KindPayload, esc[7:0], line_q, end_col, '0, '0, ErrNone);
                n        = n + 1'b1;
                mode_d   = ModeStr;
              end else begin
                rec[n]   = mk(KindError, 8'd0, line_q, end_col, '0, '0, ErrEscape);
                n        = n + 1'b1;
                halted_d = 1'b1;
              end
            end
            ModeChrOpen: begin
              if (b == CharBslash) begin
                mode_d = ModeChrEsc;
              end else begin
                lit_d  = b;
                mode_d = ModeChrClose;
              end
            end
            ModeChrEsc: begin
              if (esc[8]) begin
                lit_d  = esc[7:0];
                mode_d = ModeChrClose;
              end else begin
                rec[n]   = mk(KindError, 8'd0, line_q, end_col, '0, '0, ErrEscape);
                n        = n + 1'b1;
                halted_d = 1'b1;
              end
            end
            ModeChrClose: begin
              if (b == CharSquote) begin
                rec[n] = mk(KindChar, lit_q, line_q, tstart_q, pend_q, '0, ErrNone);
                n      = n + 1'b1;
                pend_d = '0;
                mode_d = ModeGap;
              end else begin
                rec[n]   = mk(KindError, 8'd0, line_q, end_col, '0, '0, ErrNoClose);
                n        = n + 1'b1;
                halted_d = 1'b1;
              end
            end
            default: begin
              use_gap = 1'b1;
            end
          endcase

          if (use_gap) begin
            mode_d = gap_mode;
            pend_d = gap_pend;
            if (gap_start) begin
              tstart_d = end_col;
            end
            if (gap_cnt_load) begin
              tcount_d = gap_cnt;
            end
            if (gap_emit) begin
              rec[n] = gap_rec;
              n      = n + 1'b1;
            end
          end
        end
      end
    end

    // Start of a new line, or of a new source after its end.
    if (nl) begin
      mode_d   = ModeLead;
      line_d   = nl_line;
      col_d    = '0;
      pend_d   = '0;
      lead_d   = '0;
      tstart_d = '0;
      tcount_d = '0;
      lit_d    = '0;
      has_d    = 1'b0;
    end
  end

  // Step word towards the queue; bytes without records are not queued.
  always_comb begin
    q_push_o       = fire && (n != '0);
    q_step_o.count = n;
    for (int i = 0; i < MaxResults; i++) begin
      q_step_o.recs[i] = rec[i];
    end
  end

  // Comment character register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cchar_q <= CommentReset;
    end else if (cfg_we_i) begin
      cchar_q <= cfg_data_i;
    end
  end

  // Lexer state, advanced on every accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeLead;
      line_q   <= 32'd1;
      col_q    <= '0;
      pend_q   <= '0;
      lead_q   <= '0;
      tstart_q <= '0;
      tcount_q <= '0;
      lit_q    <= '0;
      has_q    <= 1'b0;
      halted_q <= 1'b0;
    end else if (fire) begin
      mode_q   <= mode_d;
      line_q   <= line_d;
      col_q    <= col_d;
      pend_q   <= pend_d;
      lead_q   <= lead_d;
      tstart_q <= tstart_d;
      tcount_q <= tcount_d;
      lit_q    <= lit_d;
      has_q    <= has_d;
      halted_q <= halted_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/acl_step_queue.sv
// Short first-in first-out queue of step words between front and back.
// Depends on acl_pkg.
`default_nettype none

module acl_step_queue import acl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t step_i,
  output logic  ready_o,
  input  logic  pop_i,
  output logic  valid_o,
  output step_t step_o
);

  localparam int PtrWidth = $clog2(QueueDepth);
  localparam int FillWidth = $clog2(QueueDepth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(QueueDepth - 1);

  step_t                 store_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_q, rd_q;
  logic [FillWidth-1:0]  fill_q;
  logic                  do_push, do_pop;

  assign ready_o = fill_q != FillWidth'(QueueDepth);
  assign valid_o = fill_q != '0;
  assign step_o  = store_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_q] <= step_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/acl_back.sv
// Back of the lexer: takes step words from the queue and sends their
// records one per cycle, when not stalled, through the output register, marking the last one.
// Depends on acl_pkg.
`default_nettype none

module acl_back import acl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  step_t     q_step_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [ResIdxWidth-1:0] idx_q, idx_d;
  logic                   valid_q, valid_d;
  out_item_t              item_q, item_d;
  logic                   load, last;
  token_t                 cur;

  assign load = !valid_q || out_ready_i;
  assign cur  = q_step_i.recs[idx_q];
  assign last = idx_q == ResIdxWidth'(q_step_i.count - 1'b1);

  // Output register refill from the head step.
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    item_d  = item_q;
    q_pop_o = 1'b0;
    if (load) begin
      valid_d = q_valid_i;
      if (q_valid_i) begin
        item_d.result_kind  = cur.result_kind;
        item_d.value_byte   = cur.value_byte;
        item_d.line_number  = cur.line_number;
        item_d.column       = cur.column;
        item_d.space_count  = cur.space_count;
        item_d.token_length = cur.token_length;
        item_d.error_code   = cur.error_code;
        item_d.last_of_step = last;
        if (last) begin
          q_pop_o = 1'b1;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

>>> rtl/core/assembly_source_lexer_unit.sv
// Top level of the assembly source lexer: front, step queue and back.
// Depends on acl_pkg, acl_front, acl_step_queue and acl_back.
//
//   Channel   Direction  Handshake              Word
//   input     in         in_valid_i/in_ready_o  in_item_t (one source byte)
//   output    out        out_valid_o/out_ready_i out_item_t (one record)
//   config    in         cfg_we_i               cfg_data_i (comment byte)
//
// One source byte is accepted per cycle while the step queue has room.
// Each byte yields zero to three records; the back sends one record per
// cycle while out_ready_i is high, so the records of a byte leave one by one.
// The queue holds four steps, so input and output stall independently.
// After reset the comment byte is 59 and the lexer starts on line one.
`default_nettype none

module assembly_source_lexer_unit import acl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_item_t  out_item_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i
);

  logic  q_ready, q_push, q_valid, q_pop;
  step_t push_step, head_step;

  acl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_step_o   (push_step)
  );

  acl_step_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .step_i  (push_step),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .step_o  (head_step)
  );

  acl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_step_i    (head_step),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/acl_checker.sv
// Port checker for the assembly source lexer and its bind to the top level.
// Depends on acl_pkg and assembly_source_lexer_unit.
`default_nettype none

module acl_checker import acl_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output word changed while stalled");

  // An error record always closes its step.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == KindError |-> out_item_o.last_of_step)
    else $error("error record not last of its step");

  // End of file is last of its step and has no column.
  a_eof_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == KindEof
      |-> out_item_o.last_of_step && out_item_o.column == 16'd0)
    else $error("malformed end-of-file record");

  // Nothing follows a delivered error record.
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_item_o.result_kind == KindError |=> !out_valid_o)
    else $error("record after error");

  // Only error records carry an error code.
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind != KindError |-> out_item_o.error_code == ErrNone)
    else $error("error code on a non-error record");

endmodule

bind assembly_source_lexer_unit acl_checker u_acl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
